[hdl/sfp_pkg.sv]
// Shared constants, widths and elaboration-time table functions for the stereographic projector.
package sfp_pkg;

    localparam int ANGLE_FRAC_BITS = 22;
    localparam int OUT_FRAC_BITS   = 8;
    localparam int Q_FRAC          = 40;
    localparam int ANGLE_W         = 32;
    localparam int VW              = 44;
    localparam int HW              = VW / 2;
    localparam int MAG_W           = 29;
    localparam int RAD_W           = 24;
    localparam int COORD_W         = 48;
    localparam int MUL_LAT         = 4;
    localparam int DIV_STEPS       = COORD_W;
    localparam int NW              = RAD_W + VW + OUT_FRAC_BITS + 2;

    localparam logic [1:0] CFG_CENTER_LATITUDE  = 2'd0;
    localparam logic [1:0] CFG_CENTER_LONGITUDE = 2'd1;
    localparam logic [1:0] CFG_SPHERE_RADIUS    = 2'd2;

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [54:0] DEG_TO_RAD = 55'(PI_Q60 / 64'd180);
    localparam logic [27:0] DEG_TO_RAD_HI = DEG_TO_RAD[54:27];
    localparam logic [26:0] DEG_TO_RAD_LO = DEG_TO_RAD[26:0];

    localparam logic signed [ANGLE_W+1:0] TURN_S = 34'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic [30:0] TURN_U    = 31'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic [30:0] HALF_U    = 31'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [30:0] QUARTER_U = 31'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic [30:0] THREE_Q_U = 31'(64'd270 << ANGLE_FRAC_BITS);

    localparam logic signed [VW-1:0] ONE_Q40 = VW'(64'd1 << Q_FRAC);
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        int j;
        q   = 0;
        rem = 0;
        for (j = 63; j >= 0; j--)
        begin
            rem = {rem[62:0], n[j]};
            q   = {q[62:0], 1'b0};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned atan_q40(int i);
        longint signed acc;
        longint signed t;
        longint unsigned v;
        int k;
        acc = 0;
        if (i == 0)
        begin
            v = PI_Q60;
        end
        else
        begin
            for (k = 0; k < 32; k++)
            begin
                if (i * (2 * k + 1) <= 62)
                begin
                    t = longint'(udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1)));
                    acc = k[0] ? acc - t : acc + t;
                end
            end
            v = longint'(acc);
        end
        return (v + (64'd1 << 21)) >> 22;
    endfunction

    function automatic longint unsigned cordic_gain_q40(int n);
        longint unsigned p;
        longint unsigned r;
        longint unsigned b;
        int i;
        p = 64'd1 << 62;
        r = 0;
        b = 64'd1 << 62;
        for (i = 0; i < 40; i++)
        begin
            if (i < n && 2 * i <= 62)
            begin
                p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        for (i = 0; i < 32; i++)
        begin
            if (b > p)
            begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (p >= r + b)
                begin
                    p = p - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r << 9;
    endfunction

endpackage

[hdl/sfp_if.sv]
// Handshake interfaces for the point, coordinate and register-write channels.
interface sfp_point_if;
    logic               valid;
    logic               ready;
    logic signed [29:0] point_latitude;
    logic signed [30:0] point_longitude;
    modport source (output valid, output point_latitude, output point_longitude, input ready);
    modport sink (input valid, input point_latitude, input point_longitude, output ready);
endinterface

interface sfp_coord_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] east_coord;
    logic signed [47:0] north_coord;
    logic               saturated;
    modport source (output valid, output east_coord, output north_coord, output saturated,
                    input ready);
    modport sink (input valid, input east_coord, input north_coord, input saturated,
                  output ready);
endinterface

interface sfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/sfp_sincos.sv]
// Pipelined sine and cosine of an angle in degrees: range reduction, radian scaling, CORDIC.
module sfp_sincos import sfp_pkg::*;
#(
    parameter int ITERATIONS = 28
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld_in,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      vld_out,
    output logic signed [VW-1:0]      sin_out,
    output logic signed [VW-1:0]      cos_out
);

    localparam logic signed [VW-1:0] GAIN = VW'(cordic_gain_q40(ITERATIONS));

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, vf_reg;
    logic [30:0]            m_reg;
    logic [30:0]            m_next;
    logic [MAG_W-1:0]       mag_reg;
    logic [MAG_W-1:0]       mag_next;
    logic                   neg2_reg, flip2_reg, neg3_reg, flip3_reg;
    logic                   neg_next, flip_next;
    logic [56:0]            ph_reg;
    logic [55:0]            pl_reg;
    logic [83:0]            sum;
    logic [VW-1:0]          zmag;
    logic signed [ANGLE_W+1:0] a_ext;

    logic signed [VW-1:0]   x_reg [0:ITERATIONS];
    logic signed [VW-1:0]   y_reg [0:ITERATIONS];
    logic signed [VW-1:0]   z_reg [0:ITERATIONS];
    logic                   f_reg [0:ITERATIONS];
    logic                   cv_reg [0:ITERATIONS];
    logic signed [VW-1:0]   sin_reg, cos_reg;

    always_comb
    begin
        a_ext = {{2{angle[ANGLE_W-1]}}, angle};
        priority if (a_ext >= TURN_S)
            m_next = 31'(a_ext - TURN_S);
        else if (a_ext >= 0)
            m_next = 31'(a_ext);
        else if (a_ext >= -TURN_S)
            m_next = 31'(a_ext + TURN_S);
        else
            m_next = 31'(a_ext + TURN_S + TURN_S);
    end

    always_comb
    begin
        priority if (m_reg <= QUARTER_U)
        begin
            mag_next  = MAG_W'(m_reg);
            neg_next  = 1'b0;
            flip_next = 1'b0;
        end
        else if (m_reg < HALF_U)
        begin
            mag_next  = MAG_W'(HALF_U - m_reg);
            neg_next  = 1'b0;
            flip_next = 1'b1;
        end
        else if (m_reg < THREE_Q_U)
        begin
            mag_next  = MAG_W'(m_reg - HALF_U);
            neg_next  = 1'b1;
            flip_next = 1'b1;
        end
        else
        begin
            mag_next  = MAG_W'(TURN_U - m_reg);
            neg_next  = 1'b1;
            flip_next = 1'b0;
        end
    end

    assign sum  = (84'(ph_reg) << 27) + 84'(pl_reg) + (84'd1 << 41);
    assign zmag = VW'(sum[83:42]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= m_next;
            mag_reg   <= mag_next;
            neg2_reg  <= neg_next;
            flip2_reg <= flip_next;
            ph_reg    <= 57'(mag_reg) * 57'(DEG_TO_RAD_HI);
            pl_reg    <= 56'(mag_reg) * 56'(DEG_TO_RAD_LO);
            neg3_reg  <= neg2_reg;
            flip3_reg <= flip2_reg;
            x_reg[0]  <= GAIN;
            y_reg[0]  <= '0;
            z_reg[0]  <= neg3_reg ? -zmag : zmag;
            f_reg[0]  <= flip3_reg;
        end
    end

    always_comb
    begin
        cv_reg[0] = v4_reg;
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_step
        localparam logic signed [VW-1:0] ATAN_STEP = VW'(atan_q40(i));
        logic cvn_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cvn_reg <= 1'b0;
            else if (en)
                cvn_reg <= cv_reg[i];
        end

        always_comb
        begin
            cv_reg[i+1] = cvn_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][VW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_STEP;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_STEP;
                end
                f_reg[i+1] <= f_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (en)
            vf_reg <= cv_reg[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= y_reg[ITERATIONS];
            cos_reg <= f_reg[ITERATIONS] ? -x_reg[ITERATIONS] : x_reg[ITERATIONS];
        end
    end

    assign vld_out = vf_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

[hdl/sfp_mulq.sv]
// Four-stage signed Q40 multiplier with round-half-up on the magnitude.
module sfp_mulq import sfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    output logic                 vld_out,
    output logic signed [VW-1:0] p
);

    logic [MUL_LAT-1:0]  v_reg;
    logic [VW-1:0]       ua_reg, ub_reg;
    logic                s1_reg, s2_reg, s3_reg;
    logic [VW-1:0]       hh_reg, hl_reg, lh_reg, ll_reg;
    logic [2*VW+1:0]     sum;
    logic [VW-1:0]       mag_reg;
    logic signed [VW-1:0] p_reg;

    assign sum = ((2*VW+2)'(hh_reg) << (2*HW))
               + (((2*VW+2)'(hl_reg) + (2*VW+2)'(lh_reg)) << HW)
               + (2*VW+2)'(ll_reg)
               + ((2*VW+2)'(1) << (Q_FRAC - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[MUL_LAT-2:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg  <= a[VW-1] ? VW'(-a) : VW'(a);
            ub_reg  <= b[VW-1] ? VW'(-b) : VW'(b);
            s1_reg  <= a[VW-1] ^ b[VW-1];
            hh_reg  <= VW'(ua_reg[VW-1:HW]) * VW'(ub_reg[VW-1:HW]);
            hl_reg  <= VW'(ua_reg[VW-1:HW]) * VW'(ub_reg[HW-1:0]);
            lh_reg  <= VW'(ua_reg[HW-1:0]) * VW'(ub_reg[VW-1:HW]);
            ll_reg  <= VW'(ua_reg[HW-1:0]) * VW'(ub_reg[HW-1:0]);
            s2_reg  <= s1_reg;
            mag_reg <= sum[Q_FRAC +: VW];
            s3_reg  <= s2_reg;
            p_reg   <= s3_reg ? -mag_reg : mag_reg;
        end
    end

    assign vld_out = v_reg[MUL_LAT-1];
    assign p       = p_reg;

endmodule

[hdl/stereographic_forward_projection.sv]
// Top level of the forward stereographic projector.
// Forward spherical stereographic projection, one point accepted per clock cycle when the
// result side keeps up. The pipeline holds one input register, three parallel sine/cosine
// pipelines of CORDIC_ITERATIONS + 5 stages, two ranks of four-stage multipliers, five
// stages that form the denominator and the scaled numerators, a 48-step restoring divider
// with one quotient bit per stage and a final saturation register. A stalled result word
// holds the whole pipeline; register writes are accepted in every cycle and must only be
// made while no point is in flight.
module stereographic_forward_projection import sfp_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 28
)
(
    input  logic        clk,
    input  logic        rst_n,
    sfp_point_if.sink   points,
    sfp_coord_if.source coords,
    sfp_cfg_if.sink     cfg
);

    typedef struct packed {
        logic den_pos;
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
    } ctl_t;

    logic                      en;
    logic signed [29:0]        clat_reg;
    logic signed [30:0]        clon_reg;
    logic [RAD_W-1:0]          radius_reg;

    logic                      v0_reg;
    logic signed [ANGLE_W-1:0] lat_reg, dlon_reg;
    logic signed [ANGLE_W-1:0] clat_ext;

    logic                      sc_vld;
    logic signed [VW-1:0]      sl0, cl0, sl, cl, sd, cd;
    logic                      ma_vld, mb_vld;
    logic signed [VW-1:0]      clcd, sl0sl, numx_a, clsl, cl0clcd, sl0clcd;
    logic signed [VW-1:0]      sl0_d [0:MUL_LAT-1];
    logic signed [VW-1:0]      cl0_d [0:MUL_LAT-1];
    logic signed [VW-1:0]      sl0sl_d [0:MUL_LAT-1];
    logic signed [VW-1:0]      numx_d [0:MUL_LAT-1];
    logic signed [VW-1:0]      clsl_d [0:MUL_LAT-1];

    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [VW-1:0]      den1_reg, numx1_reg, numy1_reg;
    logic [VW-1:0]             den2_reg, magx_reg, magy_reg;
    ctl_t                      ctl2_reg, ctl3_reg, ctl4_reg;
    logic [VW-1:0]             den3_reg, den4_reg;
    logic [RAD_W+HW-1:0]       pxh_reg, pxl_reg, pyh_reg, pyl_reg;
    logic [NW-1:0]             nx_reg, ny_reg;
    logic [NW-1:0]             nx_next, ny_next;

    logic                      dv_reg   [0:DIV_STEPS];
    ctl_t                      dctl_reg [0:DIV_STEPS];
    logic [VW-1:0]             dden_reg [0:DIV_STEPS];
    logic [VW-1:0]             rem_reg  [0:1][0:DIV_STEPS];
    logic [COORD_W-1:0]        nq_reg   [0:1][0:DIV_STEPS];
    logic                      ovf_reg  [0:1];

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] east_reg, north_reg;
    logic                      sat_reg;
    logic signed [COORD_W-1:0] east_next, north_next;
    logic                      big_x, big_y;

    assign en           = !out_valid_reg || coords.ready;
    assign points.ready = en;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clat_reg   <= '0;
            clon_reg   <= '0;
            radius_reg <= RAD_W'(1737400);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CENTER_LATITUDE:  clat_reg   <= cfg.data[29:0];
                CFG_CENTER_LONGITUDE: clon_reg   <= cfg.data;
                CFG_SPHERE_RADIUS:    radius_reg <= cfg.data[RAD_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= points.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_reg  <= {{2{points.point_latitude[29]}}, points.point_latitude};
            dlon_reg <= {points.point_longitude[30], points.point_longitude}
                      - {clon_reg[30], clon_reg};
        end
    end

    assign clat_ext = {{2{clat_reg[29]}}, clat_reg};

    sfp_sincos #(.ITERATIONS(CORDIC_ITERATIONS)) u_sc_center
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v0_reg), .angle(clat_ext),
        .vld_out(), .sin_out(sl0), .cos_out(cl0)
    );

    sfp_sincos #(.ITERATIONS(CORDIC_ITERATIONS)) u_sc_lat
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v0_reg), .angle(lat_reg),
        .vld_out(sc_vld), .sin_out(sl), .cos_out(cl)
    );

    sfp_sincos #(.ITERATIONS(CORDIC_ITERATIONS)) u_sc_dlon
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v0_reg), .angle(dlon_reg),
        .vld_out(), .sin_out(sd), .cos_out(cd)
    );

    sfp_mulq u_mul_clcd
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(sc_vld), .a(cl), .b(cd),
        .vld_out(ma_vld), .p(clcd)
    );

    sfp_mulq u_mul_sl0sl
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(sc_vld), .a(sl0), .b(sl),
        .vld_out(), .p(sl0sl)
    );

    sfp_mulq u_mul_numx
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(sc_vld), .a(cl), .b(sd),
        .vld_out(), .p(numx_a)
    );

    sfp_mulq u_mul_clsl
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(sc_vld), .a(cl0), .b(sl),
        .vld_out(), .p(clsl)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl0_d[0]   <= sl0;
            cl0_d[0]   <= cl0;
            sl0sl_d[0] <= sl0sl;
            numx_d[0]  <= numx_a;
            clsl_d[0]  <= clsl;
            for (int k = 1; k < MUL_LAT; k++)
            begin
                sl0_d[k]   <= sl0_d[k-1];
                cl0_d[k]   <= cl0_d[k-1];
                sl0sl_d[k] <= sl0sl_d[k-1];
                numx_d[k]  <= numx_d[k-1];
                clsl_d[k]  <= clsl_d[k-1];
            end
        end
    end

    sfp_mulq u_mul_cl0clcd
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(ma_vld), .a(cl0_d[MUL_LAT-1]), .b(clcd),
        .vld_out(mb_vld), .p(cl0clcd)
    );

    sfp_mulq u_mul_sl0clcd
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(ma_vld), .a(sl0_d[MUL_LAT-1]), .b(clcd),
        .vld_out(), .p(sl0clcd)
    );

    assign nx_next = ((((NW'(pxh_reg) << HW) + NW'(pxl_reg)) << (1 + OUT_FRAC_BITS))
                   + NW'(den3_reg >> 1));
    assign ny_next = ((((NW'(pyh_reg) << HW) + NW'(pyl_reg)) << (1 + OUT_FRAC_BITS))
                   + NW'(den3_reg >> 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= mb_vld;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den1_reg  <= ONE_Q40 + sl0sl_d[MUL_LAT-1] + cl0clcd;
            numx1_reg <= numx_d[MUL_LAT-1];
            numy1_reg <= clsl_d[MUL_LAT-1] - sl0clcd;

            den2_reg         <= den1_reg;
            ctl2_reg.den_pos <= !den1_reg[VW-1] && (den1_reg != '0);
            ctl2_reg.neg_x   <= numx1_reg[VW-1];
            ctl2_reg.neg_y   <= numy1_reg[VW-1];
            ctl2_reg.zero_x  <= numx1_reg == '0;
            ctl2_reg.zero_y  <= numy1_reg == '0;
            magx_reg         <= numx1_reg[VW-1] ? VW'(-numx1_reg) : VW'(numx1_reg);
            magy_reg         <= numy1_reg[VW-1] ? VW'(-numy1_reg) : VW'(numy1_reg);

            den3_reg <= den2_reg;
            ctl3_reg <= ctl2_reg;
            pxh_reg  <= (RAD_W+HW)'(radius_reg) * (RAD_W+HW)'(magx_reg[VW-1:HW]);
            pxl_reg  <= (RAD_W+HW)'(radius_reg) * (RAD_W+HW)'(magx_reg[HW-1:0]);
            pyh_reg  <= (RAD_W+HW)'(radius_reg) * (RAD_W+HW)'(magy_reg[VW-1:HW]);
            pyl_reg  <= (RAD_W+HW)'(radius_reg) * (RAD_W+HW)'(magy_reg[HW-1:0]);

            den4_reg <= den3_reg;
            ctl4_reg <= ctl3_reg;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;

            dden_reg[0]  <= den4_reg;
            dctl_reg[0]  <= ctl4_reg;
            ovf_reg[0]   <= VW'(nx_reg[NW-1:COORD_W]) >= den4_reg;
            ovf_reg[1]   <= VW'(ny_reg[NW-1:COORD_W]) >= den4_reg;
            rem_reg[0][0] <= VW'(nx_reg[NW-1:COORD_W]);
            rem_reg[1][0] <= VW'(ny_reg[NW-1:COORD_W]);
            nq_reg[0][0]  <= nx_reg[COORD_W-1:0];
            nq_reg[1][0]  <= ny_reg[COORD_W-1:0];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j+1] <= 1'b0;
            else if (en)
                dv_reg[j+1] <= dv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dden_reg[j+1] <= dden_reg[j];
                dctl_reg[j+1] <= dctl_reg[j];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [VW:0] trial;
            assign trial = {rem_reg[l][j], nq_reg[l][j][COORD_W-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (trial >= {1'b0, dden_reg[j]})
                    begin
                        rem_reg[l][j+1] <= VW'(trial - {1'b0, dden_reg[j]});
                        nq_reg[l][j+1]  <= {nq_reg[l][j][COORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[l][j+1] <= VW'(trial);
                        nq_reg[l][j+1]  <= {nq_reg[l][j][COORD_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    logic ovfx_d [0:DIV_STEPS];
    logic ovfy_d [0:DIV_STEPS];

    always_comb
    begin
        ovfx_d[0] = ovf_reg[0];
        ovfy_d[0] = ovf_reg[1];
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_ovf
        logic ox_reg, oy_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ox_reg <= ovfx_d[j];
                oy_reg <= ovfy_d[j];
            end
        end

        always_comb
        begin
            ovfx_d[j+1] = ox_reg;
            ovfy_d[j+1] = oy_reg;
        end
    end

    function automatic logic signed [COORD_W-1:0] finish(logic den_pos, logic neg,
                                                        logic zero, logic big,
                                                        logic rad_zero,
                                                        logic [COORD_W-1:0] q);
        logic [COORD_W-1:0] mag;
        mag = big ? COORD_MAX : q;
        if (!den_pos)
        begin
            if (rad_zero || zero)
                mag = '0;
            else
                mag = COORD_MAX;
        end
        return neg ? -mag : mag;
    endfunction

    always_comb
    begin
        big_x      = ovfx_d[DIV_STEPS] || nq_reg[0][DIV_STEPS][COORD_W-1];
        big_y      = ovfy_d[DIV_STEPS] || nq_reg[1][DIV_STEPS][COORD_W-1];
        east_next  = finish(dctl_reg[DIV_STEPS].den_pos, dctl_reg[DIV_STEPS].neg_x,
                            dctl_reg[DIV_STEPS].zero_x, big_x, radius_reg == '0,
                            nq_reg[0][DIV_STEPS]);
        north_next = finish(dctl_reg[DIV_STEPS].den_pos, dctl_reg[DIV_STEPS].neg_y,
                            dctl_reg[DIV_STEPS].zero_y, big_y, radius_reg == '0,
                            nq_reg[1][DIV_STEPS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            east_reg  <= east_next;
            north_reg <= north_next;
            sat_reg   <= !dctl_reg[DIV_STEPS].den_pos || big_x || big_y;
        end
    end

    assign coords.valid       = out_valid_reg;
    assign coords.east_coord  = east_reg;
    assign coords.north_coord = north_reg;
    assign coords.saturated   = sat_reg;

endmodule

[hdl/sfp_checker.sv]
// Port-level checks for the stereographic projector and their binding to the top level.
module sfp_checker import sfp_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COORD_W-1:0] east,
    input logic signed [COORD_W-1:0] north,
    input logic                      sat
);

    localparam logic [COORD_W-1:0] MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    // A stalled result word keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(east) && $stable(north) && $stable(sat))
        else $error("result word changed while stalled");

    // Clamping is symmetric, so the most negative code never appears.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (east != MOST_NEG) && (north != MOST_NEG))
        else $error("coordinate outside the clamped range");

    // The input side is held exactly when a result word waits.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output stall");

endmodule

bind stereographic_forward_projection sfp_checker u_sfp_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(points.ready),
    .out_valid(coords.valid),
    .out_ready(coords.ready),
    .east(coords.east_coord),
    .north(coords.north_coord),
    .sat(coords.saturated)
);

[bench/testbench.sv]
// Self-checking testbench for the forward stereographic projector, with a bit-exact predictor.
`timescale 1ns / 100ps

module testbench;
    import sfp_pkg::*;

    localparam int ITERS        = 28;
    localparam int PIPE_DELAY   = ITERS + 68;
    localparam int IDLE_LIMIT   = 8000;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 800;
    localparam longint ONE_DEG  = 64'd1 << ANGLE_FRAC_BITS;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned PI_60 = 64'h3243F6A8885A308D;
    localparam longint ONE_40 = 64'd1 << 40;
    localparam longint COORD_LIMIT = (64'd1 << 47) - 1;

    typedef struct packed {
        logic signed [47:0] east_coord;
        logic signed [47:0] north_coord;
        logic               saturated;
    } coord_word_t;

    typedef enum logic { ROW_CFG, ROW_POINT } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         index;
        logic [30:0]        data;
        logic signed [29:0] lat;
        logic signed [30:0] lon;
        bit                 typed;
        coord_word_t        word;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sfp_point_if points ();
    sfp_coord_if coords ();
    sfp_cfg_if   cfg ();

    stereographic_forward_projection #(.CORDIC_ITERATIONS(ITERS)) i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points),
        .coords (coords),
        .cfg    (cfg)
    );

    longint      atan_q40_tab [40];
    longint      gain_q40;
    longint      centre_lat;
    longint      centre_lon;
    longint      radius_m;
    coord_word_t expected_coords [$];
    stim_row_t   stim_rows [$];
    int          errors;
    int          idle_cycles;
    int          hold_token;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void build_trig_tables();
        longint          acc;
        longint          t;
        longint unsigned v;
        longint unsigned p;
        longint unsigned r;
        longint unsigned b;
        for (int i = 0; i < 40; i++)
        begin
            if (i == 0)
            begin
                v = PI_60;
            end
            else
            begin
                acc = 0;
                for (int k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    t = longint'((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
                    acc = (k % 2 == 1) ? acc - t : acc + t;
                end
                v = longint'(acc);
            end
            atan_q40_tab[i] = longint'((v + (64'd1 << 21)) >> 22);
        end
        p = 64'd1 << 62;
        for (int i = 0; i < ITERS; i++)
        begin
            if (2 * i <= 62)
            begin
                p = p - p / ((64'd1 << (2 * i)) + 64'd1);
            end
        end
        r = 0;
        b = 64'd1 << 62;
        while (b > p)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (p >= r + b)
            begin
                p = p - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        gain_q40 = longint'(r << 9);
    endfunction

    function automatic void sin_cos_deg(input longint a, output longint s, output longint c);
        longint full;
        longint half;
        longint quarter;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        bit     neg;
        logic [127:0] p;
        full = 360 * ONE_DEG;
        half = 180 * ONE_DEG;
        quarter = 90 * ONE_DEG;
        flip = 1'b0;
        r = a % full;
        if (r < 0) r = r + full;
        if (r >= half) r = r - full;
        if (r > quarter)
        begin
            r = half - r;
            flip = 1'b1;
        end
        else if (r < -quarter)
        begin
            r = -half - r;
            flip = 1'b1;
        end
        neg = r < 0;
        p = 128'(neg ? -r : r) * 128'(PI_60 / 64'd180);
        p = (p + (128'd1 << (19 + ANGLE_FRAC_BITS))) >> (20 + ANGLE_FRAC_BITS);
        z = neg ? -longint'(p[63:0]) : longint'(p[63:0]);
        x = gain_q40;
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q40_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q40_tab[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint mul_q40(longint a, longint b);
        logic [127:0] p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        p = 128'(64'(a < 0 ? -a : a)) * 128'(64'(b < 0 ? -b : b));
        p = (p + (128'd1 << 39)) >> 40;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint scale_coord(longint num, longint den, inout logic sat);
        logic [127:0] q;
        if (den <= 0)
        begin
            sat = 1'b1;
            if (radius_m == 0 || num == 0) return 0;
            return num > 0 ? COORD_LIMIT : -COORD_LIMIT;
        end
        q = (128'(radius_m) * 128'(64'(num < 0 ? -num : num))) << (1 + OUT_FRAC_BITS);
        q = (q + 128'(den / 2)) / 128'(den);
        if (q > 128'(COORD_LIMIT))
        begin
            sat = 1'b1;
            q = 128'(COORD_LIMIT);
        end
        return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic coord_word_t project_point(logic signed [29:0] lat,
                                                  logic signed [30:0] lon);
        longint      sl0, cl0, sl, cl, sd, cd, clcd, den, numx, numy;
        coord_word_t w;
        logic        sat;
        sat = 1'b0;
        sin_cos_deg(centre_lat, sl0, cl0);
        sin_cos_deg(longint'(lat), sl, cl);
        sin_cos_deg(longint'(lon) - centre_lon, sd, cd);
        clcd = mul_q40(cl, cd);
        den = ONE_40 + mul_q40(sl0, sl) + mul_q40(cl0, clcd);
        numx = mul_q40(cl, sd);
        numy = mul_q40(cl0, sl) - mul_q40(sl0, clcd);
        w.east_coord = 48'(scale_coord(numx, den, sat));
        w.north_coord = 48'(scale_coord(numy, den, sat));
        w.saturated = sat;
        return w;
    endfunction

    function automatic void add_point(longint lat, longint lon);
        stim_row_t row;
        row = '{ROW_POINT, '0, '0, 30'(lat), 31'(lon), 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_typed_point(longint lat, longint lon, coord_word_t w);
        stim_row_t row;
        row = '{ROW_POINT, '0, '0, 30'(lat), 31'(lon), 1'b1, w};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [1:0] index, longint data);
        stim_row_t row;
        row = '{ROW_CFG, index, 31'(data), '0, '0, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    task automatic wait_idle();
        while (expected_coords.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DELAY + 20) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [30:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (index)
            CFG_CENTER_LATITUDE:  centre_lat = longint'(signed'(data[29:0]));
            CFG_CENTER_LONGITUDE: centre_lon = longint'(signed'(data[30:0]));
            CFG_SPHERE_RADIUS:    radius_m = longint'(data[23:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_point(stim_row_t row);
        int r;
        int gap;
        points.valid <= 1'b1;
        points.point_latitude <= row.lat;
        points.point_longitude <= row.lon;
        do @(posedge clk); while (!points.ready);
        expected_coords.push_back(row.typed ? row.word : project_point(row.lat, row.lon));
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        if (gap != 0)
        begin
            points.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic longint pick_angle(longint limit, int w);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return limit;
        if (r == 1) return -limit;
        if (r == 2) return 0;
        if (r == 3) return longint'($urandom()) << 32 >>> (64 - w);
        return longint'($urandom_range(0, 2 * limit)) - limit;
    endfunction

    task automatic random_phase(int n_items);
        stim_row_t row;
        int        r;
        longint    lat;
        longint    lon;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                lat = longint'($urandom_range(0, 180 * ONE_DEG)) - 90 * ONE_DEG;
                lon = longint'($urandom_range(0, 360 * ONE_DEG)) - 180 * ONE_DEG;
            end
            else if (r < 9)
            begin
                lat = longint'($urandom());
                lon = longint'($urandom());
            end
            else
            begin
                lat = -centre_lat + $urandom_range(0, 8) - 4;
                lon = centre_lon + 180 * ONE_DEG + $urandom_range(0, 8) - 4;
            end
            row = '{ROW_POINT, '0, '0, 30'(lat), 31'(lon), 1'b0, '0};
            send_point(row);
        end
        points.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (points.valid && points.ready || coords.valid && coords.ready
            || cfg.valid && cfg.ready)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    int hold_seen;
    int hold_left;
    int run_left;

    always @(posedge clk)
    begin
        coord_word_t want;
        int          r;
        if (coords.valid && coords.ready)
        begin
            if (expected_coords.size() == 0)
            begin
                $display("%0t: unexpected word east %h north %h sat %b", $time,
                         coords.east_coord, coords.north_coord, coords.saturated);
                errors++;
            end
            else
            begin
                want = expected_coords.pop_front();
                if (coords.east_coord !== want.east_coord)
                begin
                    $display("%0t: east_coord expected %h actual %h", $time,
                             want.east_coord, coords.east_coord);
                    errors++;
                end
                if (coords.north_coord !== want.north_coord)
                begin
                    $display("%0t: north_coord expected %h actual %h", $time,
                             want.north_coord, coords.north_coord);
                    errors++;
                end
                if (coords.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, coords.saturated);
                    errors++;
                end
            end
        end
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            coords.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            coords.ready <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left <= run_left - 1;
        end
        else if (!coords.ready)
        begin
            coords.ready <= 1'b1;
            r = $urandom_range(0, 7);
            run_left <= (r == 0) ? 200 : $urandom_range(0, 30);
        end
        else
        begin
            coords.ready <= 1'b0;
            r = $urandom_range(0, 9);
            run_left <= (r == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        points.valid = 1'b0;
        points.point_latitude = '0;
        points.point_longitude = '0;
        coords.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        errors = 0;
        idle_cycles = 0;
        hold_token = 0;
        hold_seen = 0;
        hold_left = 0;
        run_left = 0;
        centre_lat = 0;
        centre_lon = 0;
        radius_m = 1737400;
        build_trig_tables();

        // Edge points at the reset radius first; a zero radius later gives zero coordinates.
        add_point(0, 0);
        add_point(90 * ONE_DEG, 0);
        add_point(-90 * ONE_DEG, 0);
        add_point(0, 180 * ONE_DEG);
        add_point(0, -180 * ONE_DEG);
        add_point(0, 180 * ONE_DEG - 1);
        add_point(-(64'd1 << 29), -(64'd1 << 30));
        add_point((64'd1 << 29) - 1, (64'd1 << 30) - 1);
        add_point(45 * ONE_DEG, 45 * ONE_DEG);
        add_point(-30 * ONE_DEG, 120 * ONE_DEG);
        add_cfg(CFG_SPHERE_RADIUS, 16777215);
        add_point(0, 179 * ONE_DEG);
        add_point(1, 1);
        add_cfg(CFG_SPHERE_RADIUS, 0);
        add_typed_point(10 * ONE_DEG, 10 * ONE_DEG, '0);
        add_cfg(CFG_SPHERE_RADIUS, 1);
        add_cfg(CFG_UNUSED, 64'h7FFFFFFF);
        add_point(20 * ONE_DEG, -20 * ONE_DEG);
        add_cfg(CFG_CENTER_LATITUDE, 90 * ONE_DEG);
        add_cfg(CFG_CENTER_LONGITUDE, -180 * ONE_DEG);
        add_cfg(CFG_SPHERE_RADIUS, 6371000);
        add_point(-90 * ONE_DEG, 0);
        add_point(0, 0);
        add_cfg(CFG_CENTER_LATITUDE, -90 * ONE_DEG);
        add_cfg(CFG_CENTER_LONGITUDE, 180 * ONE_DEG);
        add_point(90 * ONE_DEG, 17 * ONE_DEG);
        add_point(-45 * ONE_DEG, -77 * ONE_DEG);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                points.valid <= 1'b0;
                wait_idle();
                write_register(stim_rows[i].index, stim_rows[i].data);
            end
            else
            begin
                send_point(stim_rows[i]);
            end
        end
        points.valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            write_register(CFG_CENTER_LATITUDE, 31'($urandom()) ^ 31'(pick_angle(90 * ONE_DEG, 30)));
            write_register(CFG_CENTER_LONGITUDE, 31'(pick_angle(180 * ONE_DEG, 31)));
            write_register(CFG_SPHERE_RADIUS, (ph == 0) ? 31'd16777215 : (ph == 1) ? 31'd1
                           : (ph % 3 == 0) ? 31'($urandom()) : 31'($urandom_range(1000, 8000000)));
            if (ph == 2)
            begin
                hold_token <= hold_token + 1;
            end
            random_phase(RANDOM_ITEMS / 8);
        end

        wait_idle();
        if (errors == 0 && expected_coords.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
